// File: rtl/l2chs_pkg.sv
// ----------------------------------------------------------------------------
// l2chs_pkg
// Shared types, constants and the divider step function for the LBA to CHS
// address unit.
// ----------------------------------------------------------------------------
package l2chs_pkg;

    localparam int LBA_W          = 32;
    localparam int GEOM_W         = 8;    // widest divisor (heads)
    localparam int SPT_W          = 6;
    localparam int CYL_W          = 10;
    localparam int BYTE_W         = 8;
    localparam int STEPS_PER_STG  = 8;
    localparam int DIV_STAGES     = LBA_W / STEPS_PER_STG;  // stages per division
    localparam int NUM_DIV        = 2 * DIV_STAGES;         // both divisions
    localparam int NUM_STG        = NUM_DIV + 1;            // plus output stage

    localparam int CFG_IDX_W      = 8;
    localparam int CFG_DATA_W     = 8;

    localparam logic [CFG_IDX_W-1:0] REG_HEADS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SPT   = CFG_IDX_W'(1);

    localparam logic [GEOM_W-1:0] DEFAULT_HEADS = GEOM_W'(255);
    localparam logic [SPT_W-1:0]  DEFAULT_SPT   = SPT_W'(63);
    localparam logic [CYL_W-1:0]  MAX_CYLINDER  = CYL_W'(1023);

    // partial remainder plus a word that shifts dividend out and quotient in
    typedef struct packed {
        logic [GEOM_W-1:0] rem;
        logic [LBA_W-1:0]  word;
    } t_div_st;

    // eight restoring-division steps; rem is always below the divisor
    function automatic t_div_st div_steps(input t_div_st s, input logic [GEOM_W-1:0] d);
        t_div_st           st;
        logic [GEOM_W:0]   trial;
        logic              ge;
        st = s;
        for (int i = 0; i < STEPS_PER_STG; i++) begin
            trial   = {st.rem, st.word[LBA_W-1]};
            ge      = (trial >= {1'b0, d});
            st.word = {st.word[LBA_W-2:0], ge};
            st.rem  = ge ? GEOM_W'(trial - {1'b0, d}) : trial[GEOM_W-1:0];
        end
        return st;
    endfunction

endpackage

// File: rtl/lba_to_chs_address_unit.sv
// ----------------------------------------------------------------------------
// lba_to_chs_address_unit
// Converts a 32-bit logical block address to a packed cylinder/head/sector
// triple using a fully pipelined pair of restoring dividers.
// ----------------------------------------------------------------------------
// Usage: one address per clock while o_in_stall is low. A result becomes
// valid once it has passed nine register stages.
// Stages 0-3 divide the address by the
// sectors-per-track value (eight quotient bits per stage), stages 4-7 divide
// that quotient by the head count, stage 8 applies the cylinder cap and packs
// the three bytes. Each stage has its own valid bit and advances whenever it
// is empty or its successor advances, so bubbles close up and a stalled
// output only back-pressures the input once the whole pipe is full. Geometry
// registers (index 0 heads, index 1 sectors per track; zero selects 255 and
// 63) are read live by the dividers, so write them only with the pipe empty.
// The configuration port never stalls.
module lba_to_chs_address_unit
    import l2chs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // address input
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [LBA_W-1:0]      i_block_address,
    // CHS result
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [BYTE_W-1:0]     o_head_byte,
    output logic [BYTE_W-1:0]     o_sector_cyl_high,
    output logic [BYTE_W-1:0]     o_cylinder_low,
    output logic                  o_saturated
);

    // ---------------------------------------------------------------- config
    logic [GEOM_W-1:0] r_heads;
    logic [SPT_W-1:0]  r_spt;
    logic [GEOM_W-1:0] w_heads_eff;
    logic [SPT_W-1:0]  w_spt_eff;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heads <= DEFAULT_HEADS;
            r_spt   <= DEFAULT_SPT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_HEADS: r_heads <= i_cfg_data[GEOM_W-1:0];
                REG_SPT:   r_spt   <= i_cfg_data[SPT_W-1:0];
                default:   ;   // unknown index: write dropped
            endcase
        end
    end

    // zero selects the default, so no divisor is ever zero
    assign w_heads_eff = (r_heads == '0) ? DEFAULT_HEADS : r_heads;
    assign w_spt_eff   = (r_spt   == '0) ? DEFAULT_SPT   : r_spt;

    // ------------------------------------------------------- flow control
    logic [NUM_STG-1:0] r_vld;
    logic [NUM_STG-1:0] w_rdy;   // stage may load this cycle

    always_comb begin
        w_rdy[NUM_STG-1] = !r_vld[NUM_STG-1] || !i_out_stall;
        for (int k = NUM_STG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign o_in_stall = !w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NUM_STG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------ divider stages
    t_div_st          r_div  [NUM_DIV];
    t_div_st          n_div  [NUM_DIV];
    logic [SPT_W-1:0] r_sect [DIV_STAGES];   // lba mod spt, carried alongside

    genvar g;
    generate
        for (g = 0; g < NUM_DIV; g++) begin : g_div
            t_div_st w_src;
            if (g == 0) begin : g_first
                assign w_src = '{rem: '0, word: i_block_address};
            end else if (g == DIV_STAGES) begin : g_second
                // quotient of the first division enters the second
                assign w_src = '{rem: '0, word: r_div[g-1].word};
            end else begin : g_mid
                assign w_src = r_div[g-1];
            end

            if (g < DIV_STAGES) begin : g_by_spt
                assign n_div[g] = div_steps(w_src, GEOM_W'(w_spt_eff));
            end else begin : g_by_heads
                assign n_div[g] = div_steps(w_src, w_heads_eff);
            end

            always_ff @(posedge i_clk) begin
                if (w_rdy[g] && ((g == 0) ? i_in_valid : r_vld[(g == 0) ? 0 : g-1])) begin
                    r_div[g] <= n_div[g];
                end
            end

            if (g >= DIV_STAGES) begin : g_sect
                logic [SPT_W-1:0] w_sect_src;
                if (g == DIV_STAGES) begin : g_sect_first
                    assign w_sect_src = r_div[g-1].rem[SPT_W-1:0];
                end else begin : g_sect_mid
                    assign w_sect_src = r_sect[g-DIV_STAGES-1];
                end
                always_ff @(posedge i_clk) begin
                    if (w_rdy[g] && r_vld[g-1]) begin
                        r_sect[g-DIV_STAGES] <= w_sect_src;
                    end
                end
            end
        end
    endgenerate

    // -------------------------------------------------------- output stage
    logic [LBA_W-1:0]  w_cyl_full;
    logic              n_sat;
    logic [CYL_W-1:0]  n_cyl;
    logic [GEOM_W-1:0] n_head;
    logic [SPT_W-1:0]  n_sector;

    assign w_cyl_full = r_div[NUM_DIV-1].word;

    always_comb begin
        n_sat = (w_cyl_full > LBA_W'(MAX_CYLINDER));
        if (n_sat) begin
            // capped to the last addressable CHS position
            n_cyl    = MAX_CYLINDER;
            n_head   = w_heads_eff - GEOM_W'(1);
            n_sector = w_spt_eff;
        end else begin
            n_cyl    = w_cyl_full[CYL_W-1:0];
            n_head   = r_div[NUM_DIV-1].rem;
            n_sector = r_sect[DIV_STAGES-1] + SPT_W'(1);
        end
    end

    logic [BYTE_W-1:0] r_head_byte;
    logic [BYTE_W-1:0] r_sector_cyl_high;
    logic [BYTE_W-1:0] r_cylinder_low;
    logic              r_saturated;

    always_ff @(posedge i_clk) begin
        if (w_rdy[NUM_STG-1] && r_vld[NUM_STG-2]) begin
            r_head_byte       <= n_head;
            r_sector_cyl_high <= {n_cyl[CYL_W-1:BYTE_W], n_sector};
            r_cylinder_low    <= n_cyl[BYTE_W-1:0];
            r_saturated       <= n_sat;
        end
    end

    assign o_out_valid       = r_vld[NUM_STG-1];
    assign o_head_byte       = r_head_byte;
    assign o_sector_cyl_high = r_sector_cyl_high;
    assign o_cylinder_low    = r_cylinder_low;
    assign o_saturated       = r_saturated;

    // ---------------------------------------------------------- assertions
    // sector numbers start at one, capped or not
    a_sector_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sector_cyl_high[SPT_W-1:0] != '0))
        else $error("sector field is zero");

    // a capped result always carries cylinder 1023
    a_sat_cylinder : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            ((o_cylinder_low == 8'hFF) && (o_sector_cyl_high[7:6] == 2'b11)))
        else $error("saturated result without maximum cylinder");

    // an accepted address always lands in the first stage
    a_accept_loads : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_in_valid && !o_in_stall) |=> r_vld[0])
        else $error("accepted address lost at pipeline entry");

endmodule
